// ===== src/aesc_pkg.sv =====
// Package for the auto exposure shutter control block.
// Holds field widths, beat structs, register map codes and reset values.
// No dependencies.
package aesc_pkg;

  localparam int PIXEL_BITS   = 16;
  localparam int COORD_BITS   = 11;
  localparam int THRESH_BITS  = 16;
  localparam int SHUTTER_BITS = 10;
  localparam int COUNT_BITS   = 21;
  localparam int RATIO_BITS   = 4;
  localparam int PERIOD_BITS  = 4;
  localparam int LIMIT_BITS   = 6;
  localparam int SPEED_BITS   = 7;
  localparam int ADDR_BITS    = 5;
  localparam int DATA_BITS    = 32;

  // register map, word index = paddr[4:2]
  localparam logic [2:0] REG_LOW_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_HIGH_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_DOMINANCE_RATIO = 3'd2;
  localparam logic [2:0] REG_MAX_SHUTTER     = 3'd3;
  localparam logic [2:0] REG_INITIAL_SHUTTER = 3'd4;
  localparam logic [2:0] REG_UPDATE_PERIOD   = 3'd5;
  localparam logic [2:0] REG_SPEED_LIMIT     = 3'd6;

  localparam logic [THRESH_BITS-1:0]  LOW_THRESHOLD_RST   = 16'd38;
  localparam logic [THRESH_BITS-1:0]  HIGH_THRESHOLD_RST  = 16'd249;
  localparam logic [RATIO_BITS-1:0]   DOMINANCE_RATIO_RST = 4'd4;
  localparam logic [SHUTTER_BITS-1:0] MAX_SHUTTER_RST     = 10'd200;
  localparam logic [SHUTTER_BITS-1:0] INITIAL_SHUTTER_RST = 10'd64;
  localparam logic [PERIOD_BITS-1:0]  UPDATE_PERIOD_RST   = 4'd5;
  localparam logic [LIMIT_BITS-1:0]   SPEED_LIMIT_RST     = 6'd16;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  frame_end;
  } pixel_beat_t;

  typedef struct packed {
    logic [SHUTTER_BITS-1:0] shutter_time;
    logic                    recomputed;
  } shutter_beat_t;

endpackage

// ===== src/auto_exposure_shutter_control.sv =====
// Auto exposure shutter control: histogram clipping on a pixel stream.
// Depends on aesc_pkg (widths, beat structs, register map).

// Takes one pixel beat per clock (but for the stall below) and gives one shutter beat for
// every pixel beat that carries frame_end. Samples are pixels at even row and
// even column; each is counted as under-exposed (<= low_threshold) and/or
// over-exposed (>= high_threshold) in saturating 21-bit counters that clear
// at every frame end, the frame-end pixel itself counted first. The first
// frame after reset reports initial_shutter; after that the shutter is
// recomputed every update_period frames (held value repeated in between,
// recomputed = 0). A recompute ramps a signed adjust speed toward the
// dominant side (bounded by speed_limit), zeroes it on a balanced count,
// and adds it to the stored shutter, clamped to 1 .. max_shutter.
// The shutter beat leaves the output register after the frame-end pixel has
// passed the input register, counter stage, ratio multiply stage and decision
// stage. Every stage moves one beat per cycle, so the block runs at one pixel
// per clock; it stalls pixel intake only when a frame-end beat has to wait
// behind a result that the consumer has not taken.
// Registers sit at paddr 4*index; pready is tied high, writes land at the
// access cycle, and must only happen while the block is idle.
module auto_exposure_shutter_control
  import aesc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // pixel stream
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  pixel_beat_t          pix,
  // shutter results
  output logic                 res_valid,
  input  logic                 res_ready,
  output shutter_beat_t        res,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int PROD_BITS = COUNT_BITS + RATIO_BITS;
  localparam int SP_BITS   = SPEED_BITS + 1;       // headroom for speed +/- 1
  localparam int SUM_BITS  = SHUTTER_BITS + 2;     // signed shutter + speed

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [THRESH_BITS-1:0]  low_threshold;
  logic [THRESH_BITS-1:0]  high_threshold;
  logic [RATIO_BITS-1:0]   dominance_ratio;
  logic [SHUTTER_BITS-1:0] max_shutter;
  logic [SHUTTER_BITS-1:0] initial_shutter;
  logic [PERIOD_BITS-1:0]  update_period;
  logic [LIMIT_BITS-1:0]   speed_limit;

  logic       cfg_write;
  logic [2:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold   <= LOW_THRESHOLD_RST;
      high_threshold  <= HIGH_THRESHOLD_RST;
      dominance_ratio <= DOMINANCE_RATIO_RST;
      max_shutter     <= MAX_SHUTTER_RST;
      initial_shutter <= INITIAL_SHUTTER_RST;
      update_period   <= UPDATE_PERIOD_RST;
      speed_limit     <= SPEED_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_LOW_THRESHOLD:   low_threshold   <= pwdata[THRESH_BITS-1:0];
        REG_HIGH_THRESHOLD:  high_threshold  <= pwdata[THRESH_BITS-1:0];
        REG_DOMINANCE_RATIO: dominance_ratio <= pwdata[RATIO_BITS-1:0];
        REG_MAX_SHUTTER:     max_shutter     <= pwdata[SHUTTER_BITS-1:0];
        REG_INITIAL_SHUTTER: initial_shutter <= pwdata[SHUTTER_BITS-1:0];
        REG_UPDATE_PERIOD:   update_period   <= pwdata[PERIOD_BITS-1:0];
        REG_SPEED_LIMIT:     speed_limit     <= pwdata[LIMIT_BITS-1:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOW_THRESHOLD:   prdata = DATA_BITS'(low_threshold);
      REG_HIGH_THRESHOLD:  prdata = DATA_BITS'(high_threshold);
      REG_DOMINANCE_RATIO: prdata = DATA_BITS'(dominance_ratio);
      REG_MAX_SHUTTER:     prdata = DATA_BITS'(max_shutter);
      REG_INITIAL_SHUTTER: prdata = DATA_BITS'(initial_shutter);
      REG_UPDATE_PERIOD:   prdata = DATA_BITS'(update_period);
      REG_SPEED_LIMIT:     prdata = DATA_BITS'(speed_limit);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. Plain pixels retire at the counter stage; only
  // frame-end beats travel on toward the output register.
  // ---------------------------------------------------------------------
  logic        v1, v2, v3;
  pixel_beat_t s1;
  logic        out_free, s3_open, s2_open;
  logic        s1_fire, s2_fire, s3_fire;

  assign out_free  = !res_valid || res_ready;
  assign s3_fire   = v3 && out_free;
  assign s3_open   = !v3 || out_free;
  assign s2_fire   = v2 && s3_open;
  assign s2_open   = !v2 || s3_open;
  assign s1_fire   = v1 && (!s1.frame_end || s2_open);
  assign pix_ready = !v1 || s1_fire;

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (pix_ready) begin
      v1 <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      s1 <= pix;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sample classification and saturating counters. A frame end
  // hands the final counts on and clears the counters.
  // ---------------------------------------------------------------------
  logic [COUNT_BITS-1:0] under_count, over_count;
  logic [COUNT_BITS-1:0] under_count_next, over_count_next;
  logic [COUNT_BITS-1:0] under_fin, over_fin;
  logic                  is_sample, under_hit, over_hit;

  assign is_sample = !s1.col[0] && !s1.row[0];
  assign under_hit = is_sample && (THRESH_BITS'(s1.pixel) <= low_threshold)
                     && !(&under_count);
  assign over_hit  = is_sample && (THRESH_BITS'(s1.pixel) >= high_threshold)
                     && !(&over_count);
  assign under_count_next = under_count + COUNT_BITS'(under_hit);
  assign over_count_next  = over_count + COUNT_BITS'(over_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      under_count <= '0;
      over_count  <= '0;
    end else if (s1_fire) begin
      if (s1.frame_end) begin
        under_count <= '0;
        over_count  <= '0;
      end else begin
        under_count <= under_count_next;
        over_count  <= over_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_open) begin
      v2 <= s1_fire && s1.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_open && s1_fire && s1.frame_end) begin
      under_fin <= under_count_next;
      over_fin  <= over_count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: ratio products for the dominance tests.
  // ---------------------------------------------------------------------
  logic [COUNT_BITS-1:0] under_q, over_q;
  logic [PROD_BITS-1:0]  under_scaled, over_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_open) begin
      v3 <= s2_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_open && s2_fire) begin
      under_q      <= under_fin;
      over_q       <= over_fin;
      under_scaled <= PROD_BITS'(dominance_ratio) * PROD_BITS'(under_fin);
      over_scaled  <= PROD_BITS'(dominance_ratio) * PROD_BITS'(over_fin);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: schedule, speed ramp, clamp, output register.
  // ---------------------------------------------------------------------
  logic [SHUTTER_BITS-1:0]    current_shutter;
  logic                       shutter_known;
  logic [PERIOD_BITS-1:0]     frames_left;
  logic signed [SPEED_BITS-1:0] adjust_speed;

  logic                       over_dom, under_dom, recompute_now;
  logic signed [SP_BITS-1:0]  sp, sp_dec, sp_inc, lim_pos, lim_neg;
  logic signed [SP_BITS-1:0]  sp_down, sp_up, speed_next;
  logic signed [SUM_BITS-1:0] sum_raw, sum_hi, sum_clamp, max_s;

  assign over_dom  = PROD_BITS'(over_q) > under_scaled;
  assign under_dom = PROD_BITS'(under_q) > over_scaled;
  assign recompute_now = shutter_known && (frames_left <= PERIOD_BITS'(1));

  always_comb begin
    sp      = SP_BITS'(adjust_speed);
    lim_pos = SP_BITS'($signed({1'b0, speed_limit}));
    lim_neg = -lim_pos;
    sp_dec  = sp - SP_BITS'(1);
    sp_inc  = sp + SP_BITS'(1);
    // over side: max(min(-1, speed - 1), -limit)
    sp_down = (sp_dec < -SP_BITS'(1)) ? sp_dec : -SP_BITS'(1);
    if (sp_down < lim_neg) begin
      sp_down = lim_neg;
    end
    // under side: min(max(1, speed + 1), limit)
    sp_up = (sp_inc > SP_BITS'(1)) ? sp_inc : SP_BITS'(1);
    if (sp_up > lim_pos) begin
      sp_up = lim_pos;
    end
    if (over_dom) begin
      speed_next = sp_down;
    end else if (under_dom) begin
      speed_next = sp_up;
    end else begin
      speed_next = '0;
    end
    max_s     = SUM_BITS'($signed({2'b00, max_shutter}));
    sum_raw   = SUM_BITS'($signed({2'b00, current_shutter})) + SUM_BITS'(speed_next);
    sum_hi    = (sum_raw < max_s) ? sum_raw : max_s;
    sum_clamp = (sum_hi > SUM_BITS'(1)) ? sum_hi : SUM_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_shutter <= '0;
      shutter_known   <= 1'b0;
      frames_left     <= '0;
      adjust_speed    <= '0;
    end else if (s3_fire) begin
      if (!shutter_known) begin
        current_shutter <= initial_shutter;
        shutter_known   <= 1'b1;
      end else if (!recompute_now) begin
        frames_left <= frames_left - PERIOD_BITS'(1);
      end else begin
        frames_left     <= update_period;
        adjust_speed    <= speed_next[SPEED_BITS-1:0];
        current_shutter <= sum_clamp[SHUTTER_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s3_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      if (!shutter_known) begin
        res.shutter_time <= initial_shutter;
        res.recomputed   <= 1'b0;
      end else if (!recompute_now) begin
        res.shutter_time <= current_shutter;
        res.recomputed   <= 1'b0;
      end else begin
        res.shutter_time <= sum_clamp[SHUTTER_BITS-1:0];
        res.recomputed   <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1.frame_end) |=> (under_count == '0 && over_count == '0))
    else $error("counters not cleared after frame end");

  a_stage2_source: assert property (@(posedge clk) disable iff (rst)
    (v2 && !$past(v2)) |-> $past(s1_fire && s1.frame_end))
    else $error("counter stage holds a beat without a frame end");

  a_recompute_known: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.recomputed) |-> (shutter_known && res.shutter_time != '0))
    else $error("recomputed shutter before first frame or out of range");

  a_period_reload: assert property (@(posedge clk) disable iff (rst)
    (s3_fire && recompute_now) |=> (frames_left == update_period))
    else $error("frame counter not reloaded on recompute");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    (s3_fire && recompute_now) |=>
      (adjust_speed <= $signed({1'b0, speed_limit})
       && adjust_speed >= -$signed({1'b0, speed_limit})))
    else $error("adjust speed beyond limit");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for auto_exposure_shutter_control: pixel frames in, shutter beats out.
// Depends on aesc_pkg for the beat structs, register map codes and reset values.
// Predicts each shutter beat in step with accepted pixels, checks beats in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import aesc_pkg::*;

  // Scene styles used to shape pixel levels around the programmed thresholds.
  typedef enum int {SCENE_DARK, SCENE_BRIGHT, SCENE_MID, SCENE_NOISE} scene_t;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int DRAIN_TAIL  = 12;   // output register sits 4 stages behind intake
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  // DUT hookup; every input starts at a known value
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_ready;
  pixel_beat_t          pix       = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  shutter_beat_t        res;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [DATA_BITS-1:0] pwdata    = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Register shadow, tracks what the block holds
  logic [THRESH_BITS-1:0]  cfg_low    = LOW_THRESHOLD_RST;
  logic [THRESH_BITS-1:0]  cfg_high   = HIGH_THRESHOLD_RST;
  logic [RATIO_BITS-1:0]   cfg_ratio  = DOMINANCE_RATIO_RST;
  logic [SHUTTER_BITS-1:0] cfg_max    = MAX_SHUTTER_RST;
  logic [SHUTTER_BITS-1:0] cfg_init   = INITIAL_SHUTTER_RST;
  logic [PERIOD_BITS-1:0]  cfg_period = UPDATE_PERIOD_RST;
  logic [LIMIT_BITS-1:0]   cfg_limit  = SPEED_LIMIT_RST;

  // Exposure state mirror
  logic [COUNT_BITS-1:0]          dark_count   = '0;
  logic [COUNT_BITS-1:0]          bright_count = '0;
  logic [SHUTTER_BITS-1:0]        held_shutter = '0;
  bit                             shutter_set  = 1'b0;
  logic [PERIOD_BITS-1:0]         frames_to_go = '0;
  logic signed [SPEED_BITS-1:0]   ramp_speed   = '0;

  pixel_beat_t   pixel_queue[$];     // pixels waiting to be driven
  shutter_beat_t shutter_queue[$];   // shutter beats owed by the block

  bit pix_took  = 1'b0;   // pixel beat accepted at the last rising edge
  bit calm      = 1'b0;   // no idling on either side once set
  int send_gap  = 0;
  int hold_left = 0;
  int errors    = 0;
  int pixels_taken, shutters_seen, recomputes_seen, settings_used;

  auto_exposure_shutter_control u_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Exposure predictor: counts samples of one pixel beat and, on frame end,
  // queues the shutter beat the block owes for that frame.
  function automatic void track_exposure(input pixel_beat_t b);
    int speed, lim, base, total, cap;
    longint dark, bright, ratio;
    shutter_beat_t outcome;
    // only pixels on even row and even column are samples
    if (!b.col[0] && !b.row[0]) begin
      if (b.pixel <= cfg_low && dark_count != COUNT_FULL) dark_count++;
      if (b.pixel >= cfg_high && bright_count != COUNT_FULL) bright_count++;
    end
    if (!b.frame_end) return;
    outcome.recomputed = 1'b0;
    if (!shutter_set) begin
      // first frame after reset reports the initial shutter as is
      held_shutter = cfg_init;
      shutter_set  = 1'b1;
    end else if (frames_to_go > 1) begin
      frames_to_go--;
    end else begin
      frames_to_go = cfg_period;
      dark   = dark_count;
      bright = bright_count;
      ratio  = cfg_ratio;
      speed  = ramp_speed;
      lim    = cfg_limit;
      // too bright is tested first; both ramps are bounded by the limit
      if (bright > ratio * dark) begin
        speed = (speed - 1 < -1) ? speed - 1 : -1;
        if (speed < -lim) speed = -lim;
      end else if (dark > ratio * bright) begin
        speed = (speed + 1 > 1) ? speed + 1 : 1;
        if (speed > lim) speed = lim;
      end else begin
        speed = 0;
      end
      base  = held_shutter;
      cap   = cfg_max;
      total = base + speed;
      if (total > cap) total = cap;
      if (total < 1) total = 1;   // lower clamp wins over a zero max
      held_shutter       = total[SHUTTER_BITS-1:0];
      ramp_speed         = speed[SPEED_BITS-1:0];
      outcome.recomputed = 1'b1;
    end
    outcome.shutter_time = held_shutter;
    shutter_queue = {shutter_queue, outcome};
    dark_count   = '0;
    bright_count = '0;
  endfunction

  // Pixel driver: holds a beat until taken, pulls the next one from the
  // queue, and inserts idle bursts between beats.
  always @(negedge clk) begin : pixel_driver
    logic        nv;
    pixel_beat_t nb;
    nv = pix_valid && !pix_took;
    nb = pix;
    if (!rst && !nv) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pixel_queue.size() != 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 10) - 1;   // this cycle is the first idle one
        end else begin
          nb = pixel_queue.pop_front();
          nv = 1'b1;
        end
      end
    end
    pix_valid <= nv;
    pix       <= nb;
  end

  // Result side backpressure, independent of res_valid so stalls hit any phase.
  always @(negedge clk) begin : result_stall
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      hold_left = $urandom_range(1, 10) - 1;
      rdy       = 1'b0;
    end
    res_ready <= rdy;
  end

  // Monitor: feeds accepted pixel beats to the predictor and checks every
  // accepted shutter beat against the oldest one owed.
  always @(posedge clk) begin : monitor
    shutter_beat_t want;
    pix_took = 1'b0;
    if (!rst && pix_valid && pix_ready) begin
      track_exposure(pix);
      pix_took = 1'b1;
      pixels_taken++;
    end
    if (!rst && res_valid && res_ready) begin
      shutters_seen++;
      if (res.recomputed) recomputes_seen++;
      if (shutter_queue.size() == 0) begin
        $display("%0t: shutter beat %0d/%0b arrived with none expected",
                 $time, res.shutter_time, res.recomputed);
        errors++;
      end else begin
        want = shutter_queue.pop_front();
        if (res.shutter_time !== want.shutter_time) begin
          $display("%0t: shutter_time expected %0d actual %0d",
                   $time, want.shutter_time, res.shutter_time);
          errors++;
        end
        if (res.recomputed !== want.recomputed) begin
          $display("%0t: recomputed expected %0b actual %0b",
                   $time, want.recomputed, res.recomputed);
          errors++;
        end
      end
    end
  end

  // APB write: setup then access; the register lands at the access edge,
  // where the shadow copy is updated too.
  task automatic write_reg(input logic [2:0] idx, input int val);
    logic [DATA_BITS-1:0] word;
    word = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_LOW_THRESHOLD:   cfg_low    = word[THRESH_BITS-1:0];
      REG_HIGH_THRESHOLD:  cfg_high   = word[THRESH_BITS-1:0];
      REG_DOMINANCE_RATIO: cfg_ratio  = word[RATIO_BITS-1:0];
      REG_MAX_SHUTTER:     cfg_max    = word[SHUTTER_BITS-1:0];
      REG_INITIAL_SHUTTER: cfg_init   = word[SHUTTER_BITS-1:0];
      REG_UPDATE_PERIOD:   cfg_period = word[PERIOD_BITS-1:0];
      REG_SPEED_LIMIT:     cfg_limit  = word[LIMIT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_all(input int lo, input int hi, input int ratio, input int cap,
                         input int init, input int period, input int lim);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_DOMINANCE_RATIO, ratio);
    write_reg(REG_MAX_SHUTTER, cap);
    write_reg(REG_INITIAL_SHUTTER, init);
    write_reg(REG_UPDATE_PERIOD, period);
    write_reg(REG_SPEED_LIMIT, lim);
    settings_used++;
  endtask

  // Wait until every pixel is in and every owed beat is out, then let the
  // pipeline empty of trailing non-frame-end pixels.
  task automatic drain();
    while (pixel_queue.size() != 0 || pix_valid || shutter_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [PIXEL_BITS-1:0] p, input logic [COORD_BITS-1:0] c,
                             input logic [COORD_BITS-1:0] r, input logic fe);
    pixel_beat_t b;
    b.pixel     = p;
    b.col       = c;
    b.row       = r;
    b.frame_end = fe;
    pixel_queue = {pixel_queue, b};
  endtask

  // Pixel level for a scene style, placed relative to the current thresholds.
  function automatic logic [PIXEL_BITS-1:0] pick_level(input scene_t scene);
    int lo, hi;
    lo = cfg_low;
    hi = cfg_high;
    case (scene)
      SCENE_DARK:   return PIXEL_BITS'($urandom_range(0, lo));
      SCENE_BRIGHT: return PIXEL_BITS'($urandom_range(hi, 65535));
      SCENE_MID:    return (hi > lo + 1) ? PIXEL_BITS'($urandom_range(lo + 1, hi - 1))
                                         : PIXEL_BITS'($urandom);
      default:      return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // Mostly even coordinates so most pixels are samples.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    logic [COORD_BITS-1:0] c;
    c = COORD_BITS'($urandom);
    if ($urandom_range(0, 4) != 0) c[0] = 1'b0;
    return c;
  endfunction

  // Short frames of one scene style with some noise pixels; now and then a
  // ragged run where frame_end falls at random.
  task automatic queue_frames(input int budget);
    int made, len, k;
    scene_t scene;
    bit ragged;
    logic [PIXEL_BITS-1:0] lvl;
    made = 0;
    while (made < budget) begin
      len    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 20);
      scene  = scene_t'($urandom_range(0, 3));
      ragged = ($urandom_range(0, 9) == 0);
      for (k = 0; k < len; k++) begin
        lvl = ($urandom_range(0, 3) == 0) ? pick_level(SCENE_NOISE) : pick_level(scene);
        queue_pixel(lvl, pick_coord(), pick_coord(),
                    ragged ? ($urandom_range(0, 3) == 0) : (k == len - 1));
      end
      made += len;
    end
  endtask

  task automatic random_setting();
    int lo;
    lo = $urandom_range(0, 30000);
    set_all(lo, lo + $urandom_range(0, 35535), $urandom_range(0, 15),
            $urandom_range(0, 1023), $urandom_range(1, 1023),
            $urandom_range(0, 15), $urandom_range(0, 63));
  endtask

  initial begin : stimulus
    int ph;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset thresholds and period, but a first-frame shutter above max_shutter.
    write_reg(REG_INITIAL_SHUTTER, 1023);
    settings_used = 1;

    // Directed frames: first frame, under-dominant recompute clamped to max,
    // held frames (odd coordinates and threshold edges), over-dominant recompute.
    queue_pixel(16'd0, 11'd0, 11'd0, 1'b1);
    queue_pixel(16'd0, 11'd0, 11'd0, 1'b0);
    queue_pixel(16'd5, 11'd2, 11'd4, 1'b0);
    queue_pixel(16'd38, 11'd2046, 11'd2046, 1'b1);
    queue_pixel(16'hFFFF, 11'd2047, 11'd2047, 1'b1);
    queue_pixel(16'd249, 11'd0, 11'd0, 1'b1);
    queue_pixel(16'd248, 11'd1, 11'd0, 1'b1);
    queue_pixel(16'hFFFF, 11'd0, 11'd2047, 1'b1);
    queue_pixel(16'hFFFF, 11'd2046, 11'd0, 1'b0);
    queue_pixel(16'd249, 11'd0, 11'd2, 1'b0);
    queue_pixel(16'd0, 11'd2, 11'd1, 1'b0);
    queue_pixel(16'd40000, 11'd4, 11'd4, 1'b1);
    queue_pixel(16'd39, 11'd6, 11'd6, 1'b1);
    queue_pixel(16'h8000, 11'h400, 11'h400, 1'b1);
    queue_frames(PHASE_ITEMS - 14);

    for (ph = 1; ph < PHASES; ph++) begin
      drain();
      case (ph)
        // nothing dark, nothing bright but the extremes; any over count wins
        1: set_all(0, 65535, 0, 1023, 1, 1, 63);
        // every sample both dark and bright; slowest update, tightest clamp
        2: set_all(65535, 0, 15, 1, 1023, 15, 1);
        // zero max_shutter, zero period, zero speed limit
        3: set_all(300, 60000, 1, 0, 1, 0, 0);
        // adjacent thresholds, short period, moderate ramp
        4: set_all(1000, 1001, 2, 512, 1, 2, 5);
        default: random_setting();
      endcase
      if (ph == PHASES - 1) calm = 1'b1;   // final stretch runs at full rate
      queue_frames(PHASE_ITEMS);
    end
    drain();

    $display("%0d pixel beats in, %0d shutter beats out (%0d recomputed)",
             pixels_taken, shutters_seen, recomputes_seen);
    $display("%0d register settings, %0d mismatches", settings_used, errors);
    if (errors == 0 && shutter_queue.size() == 0) begin
      $display("auto_exposure_shutter_control test passed");
    end else begin
      $display("auto_exposure_shutter_control test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("%0t: timeout, %0d shutter beats still owed", $time, shutter_queue.size());
    $display("auto_exposure_shutter_control test failed");
    $finish;
  end

endmodule
